// File: src/cfm_pkg.sv
package cfm_pkg;

   localparam int FREQ_W               = 28;
   localparam int CAPTURE_W            = 16;
   localparam int COUNTER_BITS_DEFAULT = 16;
   localparam int CSR_ADDR_W           = 3;
   localparam int CSR_DATA_W           = 32;

   localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET  = FREQ_W'(150000000);
   localparam logic [FREQ_W-1:0] THRESHOLD_RESET = FREQ_W'(500000);

   // register index is paddr[2]
   localparam logic REG_CLOCK_HZ  = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   typedef enum logic [1:0] {
      REQ_CAPTURE = 2'd0,
      REQ_WINDOW  = 2'd1,
      REQ_STOP    = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_ENTER = 2'd1,
      EVT_LEAVE = 2'd2
   } mode_event_type;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [CAPTURE_W-1:0] capture_value;
   } cfm_req_type;

   typedef struct packed {
      logic [FREQ_W-1:0] frequency_hz;
      logic              high_mode;
      logic [1:0]        mode_event;
      logic              detected;
      logic              present;
      logic [FREQ_W-1:0] window_captures;
   } cfm_rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] clock_hz;
      logic [FREQ_W-1:0] threshold_hz;
   } cfm_cfg_type;

endpackage

// File: src/capture_frequency_meter.sv
// channel  | ports                         | beat
// ---------+-------------------------------+-------------------------------------
// request  | req_valid/req_ready/req_data  | capture, window end or stop
// response | rsp_valid/rsp_ready/rsp_data  | one result per request
// config   | csr_psel..csr_pready (APB)    | 0x0 clock_hz, 0x4 threshold_hz
//
// A capture with a nonzero period goes through load, the radix-2 divider (one
// quotient bit per cycle), done and write-back before the next accept; other
// requests go from accept straight to write-back.
// Reset is synchronous and active high; the flags and the edge count clear at once.
// A finished result waits in the output register while the next request is
// taken; only the final update stalls when that register is still full.
module capture_frequency_meter
   import cfm_pkg::*;
#(
   parameter int COUNTER_BITS = COUNTER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cfm_req_type           req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cfm_rsp_type           rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   cfm_cfg_type           cfg;

   logic [1:0]            kind_ff, kind_in;
   logic [COUNTER_BITS-1:0] cur_ff, cur_in;
   logic                  zero_ff, zero_in;

   logic [COUNTER_BITS-1:0] prev_ff, prev_in;
   logic [FREQ_W-1:0]     edges_ff, edges_in;
   logic [FREQ_W-1:0]     freq_ff, freq_in;
   logic                  high_ff, high_in;
   logic                  det_ff, det_in;
   logic                  pres_ff, pres_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   cfm_rsp_type           rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  slot_free;
   logic                  commit;
   logic [COUNTER_BITS-1:0] cur_now;
   logic [COUNTER_BITS-1:0] period;
   logic                  div_start;
   logic                  div_done;
   logic [FREQ_W-1:0]     quotient;
   mode_event_type        evt;
   logic [FREQ_W-1:0]     win;

   cfm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cfm_divider #(
      .DIVIDEND_W (FREQ_W),
      .DIVISOR_W  (COUNTER_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cfg.clock_hz),
      .divisor  (period),
      .quotient (quotient),
      .done     (div_done)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_FINISH) && slot_free;

   // low COUNTER_BITS of the snapshot; period wraps modulo the counter range
   assign cur_now   = COUNTER_BITS'(req_data.capture_value);
   assign period    = cur_now - prev_ff;
   assign div_start = accept && (req_data.req_type == REQ_CAPTURE) && (period != '0);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      cur_in   = cur_ff;
      zero_in  = zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_data.req_type;
               cur_in   = cur_now;
               zero_in  = (period == '0);
               state_in = div_start ? ST_DIVIDE : ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            if (div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      prev_in  = prev_ff;
      edges_in = edges_ff;
      freq_in  = freq_ff;
      high_in  = high_ff;
      det_in   = det_ff;
      pres_in  = pres_ff;
      evt      = EVT_NONE;
      win      = '0;
      if (commit) begin
         case (kind_ff)
            REQ_CAPTURE: begin
               prev_in = cur_ff;
               if (edges_ff != '1) edges_in = edges_ff + FREQ_W'(1);
               det_in = 1'b1;
               if (!zero_ff) begin
                  freq_in = quotient;
                  if (quotient > cfg.threshold_hz && !high_ff) begin
                     high_in = 1'b1;
                     evt     = EVT_ENTER;
                  end else if (quotient <= cfg.threshold_hz && high_ff) begin
                     high_in = 1'b0;
                     evt     = EVT_LEAVE;
                  end
               end
            end
            REQ_WINDOW: begin
               win      = edges_ff;
               edges_in = '0;
               if (edges_ff == '0) begin
                  det_in  = 1'b0;
                  pres_in = 1'b0;
               end else begin
                  pres_in = 1'b1;
               end
            end
            REQ_STOP: begin
               high_in = 1'b0;
               det_in  = 1'b0;
               freq_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (commit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.frequency_hz    = freq_in;
         rsp_data_in.high_mode       = high_in;
         rsp_data_in.mode_event      = evt;
         rsp_data_in.detected        = det_in;
         rsp_data_in.present         = pres_in;
         rsp_data_in.window_captures = win;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         edges_ff     <= '0;
         freq_ff      <= '0;
         high_ff      <= 1'b0;
         det_ff       <= 1'b0;
         pres_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         edges_ff     <= edges_in;
         freq_ff      <= freq_in;
         high_ff      <= high_in;
         det_ff       <= det_in;
         pres_ff      <= pres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      cur_ff      <= cur_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("finished item did not reach the output register");

   // high mode is only entered above the threshold, so the frequency is nonzero
   a_high_needs_freq: assert property (@(posedge clock) disable iff (reset)
      high_ff |-> freq_ff != '0)
      else $error("high mode held with zero frequency");

endmodule

// File: src/cfm_csr.sv
module cfm_csr
   import cfm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfm_cfg_type           cfg
);

   logic [FREQ_W-1:0] clock_hz_ff, clock_hz_in;
   logic [FREQ_W-1:0] threshold_ff, threshold_in;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      clock_hz_in  = clock_hz_ff;
      threshold_in = threshold_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_CLOCK_HZ:  clock_hz_in  = csr_pwdata[FREQ_W-1:0];
            REG_THRESHOLD: threshold_in = csr_pwdata[FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= CLOCK_HZ_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         clock_hz_ff  <= clock_hz_in;
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CLOCK_HZ:  csr_prdata = CSR_DATA_W'(clock_hz_ff);
         REG_THRESHOLD: csr_prdata = CSR_DATA_W'(threshold_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.clock_hz     = clock_hz_ff;
   assign cfg.threshold_hz = threshold_ff;

endmodule

// File: src/cfm_divider.sv
module cfm_divider
   import cfm_pkg::*;
#(
   parameter int DIVIDEND_W = FREQ_W,
   parameter int DIVISOR_W  = COUNTER_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  done
);

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // one restoring step a cycle, quotient bits shift in behind the dividend
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         den_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      start |-> divisor != '0)
      else $error("divider started with zero divisor");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a running division");

endmodule
